// ----- hw/rtl/teq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_pkg: timed event queue shared definitions
// mode codes, default sizes and the result word layout
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int KIND_BITS_DEF = 4;

  localparam int MODE_W  = 2;
  localparam int TIME_W  = 64;
  localparam int KIND_W  = 4;

  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENQ_ABS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ENQ_REL = 2'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd3;

  typedef struct packed {
    logic              fired;
    logic [KIND_W-1:0] fired_kind;
    logic [TIME_W-1:0] fired_time;
    logic              found;
    logic [TIME_W-1:0] remaining;
    logic              full_error;
  } res_t;

endpackage

// ----- hw/rtl/timed_event_queue_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_queue_top: time-sorted typed event queue with a running count
// tick: add the amount to the count; if the head's time is below it, fire the head and
//   move the other entries down; enqueue: write an empty table directly, flag a full
//   one, else scan from the tail moving entries up; remove: scan for the kind, move later ones down
// one word at a time: a new word is taken only once the last is done; the slot table has a
//   single read and write port and moves one entry per cycle
// result word is registered and offered once the output register is free
// reset: count zero and table empty; slot contents are not cleared
// ----------------------------------------------------------------------------
module timed_event_queue_top #(
  parameter int SLOTS     = teq_pkg::SLOTS_DEF,
  parameter int KIND_BITS = teq_pkg::KIND_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [teq_pkg::MODE_W-1:0] in_mode,
  input  logic [teq_pkg::TIME_W-1:0] in_amount,
  input  logic [teq_pkg::KIND_W-1:0] in_kind,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_fired,
  output logic [teq_pkg::KIND_W-1:0] out_fired_kind,
  output logic [teq_pkg::TIME_W-1:0] out_fired_time,
  output logic                       out_found,
  output logic [teq_pkg::TIME_W-1:0] out_remaining,
  output logic                       out_full_error
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int OCC_W  = $clog2(SLOTS + 1);
  localparam int KW     = (KIND_BITS < teq_pkg::KIND_W) ? KIND_BITS : teq_pkg::KIND_W;
  localparam int KPW    = teq_pkg::KIND_W;
  localparam int TW     = teq_pkg::TIME_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_TADD  = 4'd1;
  localparam logic [3:0] ST_THEAD = 4'd2;
  localparam logic [3:0] ST_ICALC = 4'd3;
  localparam logic [3:0] ST_ISCAN = 4'd4;
  localparam logic [3:0] ST_ILAST = 4'd5;
  localparam logic [3:0] ST_RSCAN = 4'd6;
  localparam logic [3:0] ST_SHDN  = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0]                 state_r, state_nxt;
  logic [TW-1:0]              now_r, now_nxt;
  logic [OCC_W-1:0]           occ_r, occ_nxt;
  logic [IDX_W-1:0]           p_r, p_nxt;
  logic [TW-1:0]              amt_r, amt_nxt;
  logic [KW-1:0]              kind_r, kind_nxt;
  logic [teq_pkg::MODE_W-1:0] mode_r, mode_nxt;
  teq_pkg::res_t              res_r, res_nxt;

  logic [TW-1:0]              slot_time_mem [SLOTS];
  logic [KW-1:0]              slot_kind_mem [SLOTS];
  logic [TW-1:0]              rd_time_r;
  logic [KW-1:0]              rd_kind_r;

  logic                       mem_we;
  logic [IDX_W-1:0]           mem_waddr;
  logic [TW-1:0]              mem_wtime;
  logic [KW-1:0]              mem_wkind;
  logic [IDX_W-1:0]           mem_raddr;

  logic [OCC_W-1:0]           p_ext;
  logic                       last;
  logic [IDX_W-1:0]           p_inc;
  logic [IDX_W-1:0]           p_dec;
  logic [TW-1:0]              ins_time;
  logic                       out_load;

  assign p_ext    = OCC_W'(p_r);
  assign last     = ((p_ext + OCC_W'(1)) == occ_r);
  assign p_inc    = p_r + IDX_W'(1);
  assign p_dec    = p_r - IDX_W'(1);
  assign ins_time = (mode_r == teq_pkg::MODE_ENQ_REL) ? (now_r + amt_r) : amt_r;
  assign in_stall = (state_r != ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_nxt = state_r;
    now_nxt   = now_r;
    occ_nxt   = occ_r;
    p_nxt     = p_r;
    amt_nxt   = amt_r;
    kind_nxt  = kind_r;
    mode_nxt  = mode_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = p_r;
    mem_wtime = amt_r;
    mem_wkind = kind_r;
    mem_raddr = p_r;
    case (state_r)
      ST_IDLE: begin
        mem_raddr = '0;
        if (in_valid) begin
          amt_nxt  = in_amount;
          kind_nxt = in_kind[KW-1:0];
          mode_nxt = in_mode;
          res_nxt  = '0;
          p_nxt    = '0;
          case (in_mode)
            teq_pkg::MODE_TICK:    state_nxt = ST_TADD;
            teq_pkg::MODE_ENQ_ABS: state_nxt = ST_ICALC;
            teq_pkg::MODE_ENQ_REL: state_nxt = ST_ICALC;
            default: begin
              state_nxt = (occ_r == '0) ? ST_DONE : ST_RSCAN;
            end
          endcase
        end
      end
      ST_TADD: begin
        now_nxt   = now_r + amt_r;
        mem_raddr = '0;
        p_nxt     = '0;
        state_nxt = ST_THEAD;
      end
      ST_THEAD: begin
        mem_raddr = p_inc;
        state_nxt = ST_DONE;
        if ((occ_r != '0) && (rd_time_r < now_r)) begin
          res_nxt.fired      = 1'b1;
          res_nxt.fired_kind = KPW'(rd_kind_r);
          res_nxt.fired_time = rd_time_r;
          if (last) begin
            occ_nxt = occ_r - OCC_W'(1);
          end else begin
            p_nxt     = p_inc;
            state_nxt = ST_SHDN;
          end
        end
      end
      ST_ICALC: begin
        amt_nxt = ins_time;
        if (occ_r == OCC_W'(SLOTS)) begin
          res_nxt.full_error = 1'b1;
          state_nxt          = ST_DONE;
        end else if (occ_r == '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wtime = ins_time;
          occ_nxt   = occ_r + OCC_W'(1);
          state_nxt = ST_DONE;
        end else begin
          mem_raddr = IDX_W'(occ_r - OCC_W'(1));
          p_nxt     = IDX_W'(occ_r - OCC_W'(1));
          state_nxt = ST_ISCAN;
        end
      end
      ST_ISCAN: begin
        mem_we    = 1'b1;
        mem_waddr = p_inc;
        mem_raddr = p_dec;
        if (rd_time_r >= amt_r) begin
          mem_wtime = rd_time_r;
          mem_wkind = rd_kind_r;
          if (p_r == '0) begin
            state_nxt = ST_ILAST;
          end else begin
            p_nxt = p_dec;
          end
        end else begin
          occ_nxt   = occ_r + OCC_W'(1);
          state_nxt = ST_DONE;
        end
      end
      ST_ILAST: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        occ_nxt   = occ_r + OCC_W'(1);
        state_nxt = ST_DONE;
      end
      ST_RSCAN: begin
        mem_raddr = p_inc;
        if (rd_kind_r == kind_r) begin
          res_nxt.found     = 1'b1;
          res_nxt.remaining = rd_time_r - now_r;
          if (last) begin
            occ_nxt   = occ_r - OCC_W'(1);
            state_nxt = ST_DONE;
          end else begin
            p_nxt     = p_inc;
            state_nxt = ST_SHDN;
          end
        end else if (last) begin
          state_nxt = ST_DONE;
        end else begin
          p_nxt = p_inc;
        end
      end
      ST_SHDN: begin
        mem_we    = 1'b1;
        mem_waddr = p_dec;
        mem_wtime = rd_time_r;
        mem_wkind = rd_kind_r;
        mem_raddr = p_inc;
        if (last) begin
          occ_nxt   = occ_r - OCC_W'(1);
          state_nxt = ST_DONE;
        end else begin
          p_nxt = p_inc;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // slot table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_time_mem[mem_waddr] <= mem_wtime;
      slot_kind_mem[mem_waddr] <= mem_wkind;
    end
    rd_time_r <= slot_time_mem[mem_raddr];
    rd_kind_r <= slot_kind_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      now_r     <= '0;
      occ_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      now_r   <= now_nxt;
      occ_r   <= occ_nxt;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    amt_r  <= amt_nxt;
    kind_r <= kind_nxt;
    mode_r <= mode_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_fired      <= res_r.fired;
      out_fired_kind <= res_r.fired_kind;
      out_fired_time <= res_r.fired_time;
      out_found      <= res_r.found;
      out_remaining  <= res_r.remaining;
      out_full_error <= res_r.full_error;
    end
  end

endmodule

// ----- verif/timed_event_queue_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_queue_top_tb: self-checking bench for the timed event queue
// a scoreboard class keeps its own sorted event table and tick count, works
// out the result word for every accepted input word and checks each result
// word field by field; directed corner words come first, then random words
// in bursts that fill, drain and churn the table, with a receiver that
// stalls on a pattern of its own
// ----------------------------------------------------------------------------

class event_queue_board;

  logic [teq_pkg::TIME_W-1:0] tick_count;
  logic [teq_pkg::TIME_W-1:0] slot_t [teq_pkg::SLOTS_DEF];
  logic [teq_pkg::KIND_W-1:0] slot_k [teq_pkg::SLOTS_DEF];
  int unsigned                occupied;
  teq_pkg::res_t              awaited [$];
  int                         errors;

  function new();
    tick_count = '0;
    occupied   = 0;
    errors     = 0;
  endfunction

  // sorted insert, ahead of any entry with the same time
  function bit place(logic [teq_pkg::TIME_W-1:0] t, logic [teq_pkg::KIND_W-1:0] k);
    int unsigned pos;
    if (occupied >= teq_pkg::SLOTS_DEF) return 1'b0;
    pos = 0;
    while (pos < occupied && slot_t[pos] < t) pos++;
    for (int unsigned i = occupied; i > pos; i--) begin
      slot_t[i] = slot_t[i-1];
      slot_k[i] = slot_k[i-1];
    end
    slot_t[pos] = t;
    slot_k[pos] = k;
    occupied++;
    return 1'b1;
  endfunction

  function void take_out(int unsigned pos);
    for (int unsigned i = pos; i + 1 < occupied; i++) begin
      slot_t[i] = slot_t[i+1];
      slot_k[i] = slot_k[i+1];
    end
    occupied--;
  endfunction

  function void note_word(logic [teq_pkg::MODE_W-1:0] m, logic [teq_pkg::TIME_W-1:0] a,
                          logic [teq_pkg::KIND_W-1:0] k);
    teq_pkg::res_t r;
    logic [teq_pkg::KIND_W-1:0] kt;
    r  = '0;
    kt = k & teq_pkg::KIND_W'((1 << teq_pkg::KIND_BITS_DEF) - 1);
    case (m)
      teq_pkg::MODE_TICK: begin
        tick_count = tick_count + a;
        if (occupied > 0 && slot_t[0] < tick_count) begin
          r.fired      = 1'b1;
          r.fired_kind = slot_k[0];
          r.fired_time = slot_t[0];
          take_out(0);
        end
      end
      teq_pkg::MODE_ENQ_ABS: begin
        if (!place(a, kt)) r.full_error = 1'b1;
      end
      teq_pkg::MODE_ENQ_REL: begin
        if (!place(tick_count + a, kt)) r.full_error = 1'b1;
      end
      default: begin
        for (int unsigned i = 0; i < occupied; i++) begin
          if (slot_k[i] == kt) begin
            r.found     = 1'b1;
            r.remaining = slot_t[i] - tick_count;
            take_out(i);
            break;
          end
        end
      end
    endcase
    awaited.push_back(r);
  endfunction

  function void match(string name, logic [63:0] want, logic [63:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0h, actual %0h", name, want, seen);
      errors++;
    end
  endfunction

  function void check_word(teq_pkg::res_t got);
    teq_pkg::res_t want;
    if (awaited.size() == 0) begin
      $error("result word with nothing awaited");
      errors++;
      return;
    end
    want = awaited.pop_front();
    match("fired", 64'(want.fired), 64'(got.fired));
    match("fired_kind", 64'(want.fired_kind), 64'(got.fired_kind));
    match("fired_time", want.fired_time, got.fired_time);
    match("found", 64'(want.found), 64'(got.found));
    match("remaining", want.remaining, got.remaining);
    match("full_error", 64'(want.full_error), 64'(got.full_error));
  endfunction

endclass

module timed_event_queue_top_tb;

  localparam int ITEMS      = 1200;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN      = 3 * teq_pkg::SLOTS_DEF + 8;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [teq_pkg::MODE_W-1:0] in_mode;
  logic [teq_pkg::TIME_W-1:0] in_amount;
  logic [teq_pkg::KIND_W-1:0] in_kind;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_fired;
  logic [teq_pkg::KIND_W-1:0] out_fired_kind;
  logic [teq_pkg::TIME_W-1:0] out_fired_time;
  logic                       out_found;
  logic [teq_pkg::TIME_W-1:0] out_remaining;
  logic                       out_full_error;

  event_queue_board board;
  int               idle_cycles = 0;
  int               stall_style = 0;
  int               style_left  = 0;
  int               sq_period   = 1;
  int               sq_phase    = 0;

  timed_event_queue_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_amount      (in_amount),
    .in_kind        (in_kind),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_fired      (out_fired),
    .out_fired_kind (out_fired_kind),
    .out_fired_time (out_fired_time),
    .out_found      (out_found),
    .out_remaining  (out_remaining),
    .out_full_error (out_full_error)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic drive_word(input logic [teq_pkg::MODE_W-1:0] m,
                            input logic [teq_pkg::TIME_W-1:0] a,
                            input logic [teq_pkg::KIND_W-1:0] k);
    @(negedge clk);
    in_valid  <= 1'b1;
    in_mode   <= m;
    in_amount <= a;
    in_kind   <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word(m, a, k);
  endtask

  task automatic hold_off(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (style_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      style_left  <= $urandom_range(20, 200);
      sq_period   <= $urandom_range(1, 12);
      sq_phase    <= 0;
    end else begin
      style_left <= style_left - 1;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        out_stall <= (sq_phase < sq_period);
        if (style_left != 0) sq_phase <= (sq_phase + 1) % (2 * sq_period);
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_word('{fired: out_fired, fired_kind: out_fired_kind,
                         fired_time: out_fired_time, found: out_found,
                         remaining: out_remaining, full_error: out_full_error});
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int                         sent;
    int                         burst;
    int                         bias;
    int                         pick;
    int                         tick_cut;
    int                         rem_cut;
    logic [teq_pkg::MODE_W-1:0] m;
    logic [teq_pkg::TIME_W-1:0] a;
    logic [teq_pkg::KIND_W-1:0] k;

    board     = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_mode   = teq_pkg::MODE_TICK;
    in_amount = '0;
    in_kind   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table ticks, wrap-around times, equal times
    drive_word(teq_pkg::MODE_TICK, 64'd0, 4'h0);
    drive_word(teq_pkg::MODE_TICK, 64'd7, 4'h0);
    drive_word(teq_pkg::MODE_ENQ_ABS, '1, 4'hF);
    drive_word(teq_pkg::MODE_ENQ_ABS, 64'd0, 4'h0);
    drive_word(teq_pkg::MODE_ENQ_REL, 64'd0, 4'h3);
    drive_word(teq_pkg::MODE_ENQ_ABS, 64'd7, 4'h5);
    drive_word(teq_pkg::MODE_ENQ_REL, 64'hFFFF_FFFF_FFFF_FFF0, 4'hA);
    // fill up, last one is dropped
    for (int j = 0; j < 12; j++) begin
      if (j == 0) a = 64'hAAAA_AAAA_AAAA_AAAA;
      else if (j == 1) a = 64'h5555_5555_5555_5555;
      else a = 64'(20 + 3 * j);
      drive_word((j % 2 == 0) ? teq_pkg::MODE_ENQ_ABS : teq_pkg::MODE_ENQ_REL, a,
                 teq_pkg::KIND_W'(j % 8 + 1));
    end
    drive_word(teq_pkg::MODE_REMOVE, 64'd0, 4'h3);
    drive_word(teq_pkg::MODE_REMOVE, '1, 4'h9);
    drive_word(teq_pkg::MODE_REMOVE, 64'd0, 4'hA);
    drive_word(teq_pkg::MODE_TICK, 64'd1, 4'h0);
    drive_word(teq_pkg::MODE_TICK, 64'd0, 4'hF);
    drive_word(teq_pkg::MODE_TICK, '1, 4'h0);

    sent = 0;
    bias = 2;
    while (sent < ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && sent < ITEMS; b++) begin
        if (sent % 100 == 0) bias = $urandom_range(0, 2);
        case (bias)
          0:       begin tick_cut = 15; rem_cut = 30; end
          1:       begin tick_cut = 60; rem_cut = 75; end
          default: begin tick_cut = 40; rem_cut = 60; end
        endcase
        pick = $urandom_range(0, 99);
        k    = teq_pkg::KIND_W'($urandom_range(0, 15));
        if (pick < tick_cut) begin
          m    = teq_pkg::MODE_TICK;
          pick = $urandom_range(0, 99);
          if (pick < 70) a = 64'($urandom_range(0, 64));
          else if (pick < 90) a = 64'($urandom_range(0, 1 << 20));
          else a = {$urandom, $urandom};
        end else if (pick < rem_cut) begin
          m = teq_pkg::MODE_REMOVE;
          a = {$urandom, $urandom};
          if (board.occupied > 0 && $urandom_range(0, 9) < 7)
            k = board.slot_k[$urandom_range(0, board.occupied - 1)];
        end else if ($urandom_range(0, 1) == 0) begin
          m    = teq_pkg::MODE_ENQ_ABS;
          pick = $urandom_range(0, 99);
          if (pick < 60) a = board.tick_count + 64'($urandom_range(0, 200));
          else if (pick < 85) a = {$urandom, $urandom};
          else if (pick < 90) a = '0;
          else if (pick < 95) a = '1;
          else a = board.tick_count;
        end else begin
          m    = teq_pkg::MODE_ENQ_REL;
          pick = $urandom_range(0, 99);
          if (pick < 70) a = 64'($urandom_range(0, 200));
          else if (pick < 90) a = {$urandom, $urandom};
          else if (pick < 95) a = '0;
          else a = '1;
        end
        drive_word(m, a, k);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 15));
    end
    hold_off(1);

    while (board.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
